@@ src/rvcc_pkg.sv @@
`default_nettype none

package rvcc_pkg;

  localparam int unsigned LEVEL_COUNT = 16;
  localparam int unsigned IDX_W       = $clog2(LEVEL_COUNT);
  localparam int unsigned V_BASE      = 425;
  localparam int unsigned V_STEP      = 25;
  localparam int unsigned V_MAX       = V_BASE + V_STEP * (LEVEL_COUNT - 1);
  localparam int unsigned V_W         = $clog2(V_MAX + 1);
  localparam int unsigned RES_W       = 16;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned MV_W        = 16;
  localparam int unsigned LVL_OUT_W   = 4;
  // level = v*(1 + up/lo) < 2^V_W * 2^RES_W
  localparam int unsigned PROD_W      = V_W + RES_W;
  // room for 5*last
  localparam int unsigned WIN_W       = PROD_W + 3;
  localparam int unsigned CNT_W       = $clog2(PROD_W);

  localparam int unsigned MODE_LSB    = 13;
  localparam int unsigned CHARGE_BIT  = 15;
  localparam int unsigned SW2_LSB     = 4;
  localparam int unsigned SW3_LSB     = 0;

  typedef enum logic [1:0] {
    ACT_SET_VOLT   = 2'd0,
    ACT_SET_MODE   = 2'd1,
    ACT_SET_CHARGE = 2'd2,
    ACT_MASKED     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_SW2_UPPER = 2'd0,
    CFG_SW2_LOWER = 2'd1,
    CFG_SW3_UPPER = 2'd2,
    CFG_SW3_LOWER = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_ACC,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic capture;
    logic mul;
    logic div_step;
    logic acc;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_volt;
    logic div_done;
    logic last_level;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ src/rvcc_if.sv @@
`default_nettype none

interface rvcc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic        regulator;
  logic [15:0] millivolts;
  logic [1:0]  switch_mode;
  logic        charge_enable;
  logic [15:0] write_data;
  logic [15:0] write_mask;

  modport source (
    output valid, action, regulator, millivolts, switch_mode, charge_enable,
           write_data, write_mask,
    input  ready
  );
  modport sink (
    input  valid, action, regulator, millivolts, switch_mode, charge_enable,
           write_data, write_mask,
    output ready
  );
endinterface

interface rvcc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] control_word;
  logic        status;
  logic [3:0]  level_index;

  modport source (
    output valid, control_word, status, level_index,
    input  ready
  );
  modport sink (
    input  valid, control_word, status, level_index,
    output ready
  );
endinterface

`default_nettype wire

@@ src/rvcc_ctrl.sv @@
`default_nettype none

module rvcc_ctrl
  import rvcc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire dp_stat_t  stat_i,
  output ctrl_cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = stat_i.in_volt ? ST_MUL : ST_FIN;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = stat_i.last_level ? ST_FIN : ST_MUL;
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ src/rvcc_datapath.sv @@
`default_nettype none

module rvcc_datapath
  import rvcc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [RES_W-1:0]     cfg_data_i,
  input  wire logic [1:0]           action_i,
  input  wire logic                 regulator_i,
  input  wire logic [MV_W-1:0]      millivolts_i,
  input  wire logic [1:0]           switch_mode_i,
  input  wire logic                 charge_enable_i,
  input  wire logic [WORD_W-1:0]    write_data_i,
  input  wire logic [WORD_W-1:0]    write_mask_i,
  input  wire ctrl_cmd_t            cmd_i,
  output dp_stat_t                  stat_o,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic [WORD_W-1:0]         control_word_o,
  output logic                      status_o,
  output logic [LVL_OUT_W-1:0]      level_index_o
);

  // divider and shadow registers
  logic [RES_W-1:0]  sw2_up_q, sw2_lo_q, sw3_up_q, sw3_lo_q;
  logic [WORD_W-1:0] shadow_q;
  logic              out_valid_q;

  // latched command
  action_e           act_q;
  logic              reg_q;
  logic [MV_W-1:0]   mv_q;
  logic [1:0]        mode_q;
  logic              en_q;
  logic [WORD_W-1:0] wd_q, wm_q;
  logic [RES_W-1:0]  up_q, lo_q;

  // level sweep
  logic [IDX_W-1:0]  idx_q, chosen_q;
  logic [V_W-1:0]    v_q;
  logic [PROD_W-1:0] dvd_q;
  logic [RES_W-1:0]  rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [PROD_W-1:0] best_q, first_q, last_q;

  // result
  logic [WORD_W-1:0]    word_q;
  logic                 stat_q;
  logic [LVL_OUT_W-1:0] lvl_q;

  logic [RES_W-1:0]  up_sel, lo_sel;
  logic [RES_W:0]    trial;
  logic              qbit;
  logic [PROD_W-1:0] lvl_t, gap;
  logic [WIN_W-1:0]  last_w, first_w, dev, minv, maxv, mv_w;
  logic              reject;
  logic [WORD_W-1:0] word_d, wr_data, wr_mask;

  assign up_sel = regulator_i ? sw3_up_q : sw2_up_q;
  assign lo_sel = regulator_i ? sw3_lo_q : sw2_lo_q;

  // restoring divide, one quotient bit a cycle
  assign trial = {rem_q, dvd_q[PROD_W-1]};
  assign qbit  = (trial >= {1'b0, lo_q});

  assign lvl_t = PROD_W'(v_q) + dvd_q;
  assign gap   = (lvl_t > PROD_W'(mv_q)) ? lvl_t - PROD_W'(mv_q) : PROD_W'(mv_q) - lvl_t;

  // deviation = floor(5*last/32)
  assign last_w  = WIN_W'(last_q);
  assign first_w = WIN_W'(first_q);
  assign dev     = ((last_w << 2) + last_w) >> 5;
  assign minv    = (first_w > dev) ? first_w - dev : '0;
  assign maxv    = last_w + dev;
  assign mv_w    = WIN_W'(mv_q);
  assign reject  = (mv_w < minv) || (mv_w > maxv);

  always_comb begin
    wr_data = '0;
    wr_mask = '0;
    unique case (act_q)
      ACT_SET_VOLT: begin
        if (!reject) begin
          if (reg_q) begin
            wr_data = WORD_W'(4'(chosen_q)) << SW3_LSB;
            wr_mask = WORD_W'(4'hF) << SW3_LSB;
          end else begin
            wr_data = WORD_W'(4'(chosen_q)) << SW2_LSB;
            wr_mask = WORD_W'(4'hF) << SW2_LSB;
          end
        end
      end
      ACT_SET_MODE: begin
        wr_data = WORD_W'(mode_q) << MODE_LSB;
        wr_mask = WORD_W'(2'b11) << MODE_LSB;
      end
      ACT_SET_CHARGE: begin
        wr_data = WORD_W'(!en_q) << CHARGE_BIT;
        wr_mask = WORD_W'(1'b1) << CHARGE_BIT;
      end
      ACT_MASKED: begin
        wr_data = wd_q;
        wr_mask = wm_q;
      end
      default: ;
    endcase
    word_d = (shadow_q & ~wr_mask) | (wr_data & wr_mask);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw2_up_q    <= '0;
      sw2_lo_q    <= RES_W'(1);
      sw3_up_q    <= '0;
      sw3_lo_q    <= RES_W'(1);
      shadow_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_SW2_UPPER: sw2_up_q <= cfg_data_i;
          CFG_SW2_LOWER: sw2_lo_q <= cfg_data_i;
          CFG_SW3_UPPER: sw3_up_q <= cfg_data_i;
          CFG_SW3_LOWER: sw3_lo_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.finish) begin
        shadow_q    <= word_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q  <= action_e'(action_i);
      reg_q  <= regulator_i;
      mv_q   <= millivolts_i;
      mode_q <= switch_mode_i;
      en_q   <= charge_enable_i;
      wd_q   <= write_data_i;
      wm_q   <= write_mask_i;
      up_q   <= up_sel;
      lo_q   <= (lo_sel == '0) ? RES_W'(1) : lo_sel;
      idx_q  <= '0;
      v_q    <= V_W'(V_BASE);
    end
    if (cmd_i.mul) begin
      dvd_q <= PROD_W'(v_q) * PROD_W'(up_q);
      rem_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= qbit ? RES_W'(trial - {1'b0, lo_q}) : RES_W'(trial);
      dvd_q <= {dvd_q[PROD_W-2:0], qbit};
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.acc) begin
      if (idx_q == '0 || gap < best_q) begin
        best_q   <= gap;
        chosen_q <= idx_q;
      end
      if (idx_q == '0) begin
        first_q <= lvl_t;
      end
      last_q <= lvl_t;
      idx_q  <= idx_q + IDX_W'(1);
      v_q    <= v_q + V_W'(V_STEP);
    end
    if (cmd_i.finish) begin
      word_q <= word_d;
      stat_q <= (act_q == ACT_SET_VOLT) && reject;
      lvl_q  <= (act_q == ACT_SET_VOLT && !reject) ? LVL_OUT_W'(chosen_q) : '0;
    end
  end

  assign stat_o.in_volt    = (action_e'(action_i) == ACT_SET_VOLT);
  assign stat_o.div_done   = (cnt_q == CNT_W'(PROD_W - 1));
  assign stat_o.last_level = (idx_q == IDX_W'(LEVEL_COUNT - 1));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign control_word_o = word_q;
  assign status_o       = stat_q;
  assign level_index_o  = lvl_q;

endmodule

`default_nettype wire

@@ src/regulator_voltage_code_composer.sv @@
// Regulator voltage code composer.
// Channels: in_i (sink) takes one command beat: action, regulator, millivolts,
// switch_mode, charge_enable, write_data, write_mask. out_o (source) returns
// exactly one beat per command: control_word, status, level_index.
// cfg_we_i/cfg_idx_i/cfg_data_i write the four divider resistor registers;
// write them only while no command is in flight.
// Switch mode, charge and masked write go from acceptance straight to the final
// step. Set voltage walks the levels one at a time through a shared bit-serial
// divider (one quotient bit a cycle). One command is worked on at a time;
// in_i.ready is high only while the controller is idle.
// The result sits in an output register, so the next command is accepted
// while out_o waits. A stalled receiver holds the block in its final step
// until the register frees up.
// Reset: control word 0, upper resistors 0, lower resistors 1, no beat
// pending.
`default_nettype none

module regulator_voltage_code_composer
  import rvcc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [RES_W-1:0]  cfg_data_i,
  rvcc_in_if.sink                in_i,
  rvcc_out_if.source             out_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  rvcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rvcc_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .action_i        (in_i.action),
    .regulator_i     (in_i.regulator),
    .millivolts_i    (in_i.millivolts),
    .switch_mode_i   (in_i.switch_mode),
    .charge_enable_i (in_i.charge_enable),
    .write_data_i    (in_i.write_data),
    .write_mask_i    (in_i.write_mask),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .control_word_o  (out_o.control_word),
    .status_o        (out_o.status),
    .level_index_o   (out_o.level_index)
  );

  // a rejected voltage never reports a level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status |-> out_o.level_index == '0)
    else $error("reject beat carries a level index");

  // one command at a time: no accept in the cycle after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("second command accepted while busy");

  // the result register is never overwritten while it still waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!out_o.valid || out_o.ready))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`default_nettype none

module testbench;
  import rvcc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 1_500_000;
  localparam int     ITEMS_PER_PHASE = 126;
  localparam int     LONG_HOLD_CYCLES = 3000;
  localparam int     TAIL_CYCLES = 500;

  typedef struct packed {
    action_e               action;
    logic                  regulator;
    logic [MV_W-1:0]       millivolts;
    logic [1:0]            switch_mode;
    logic                  charge_enable;
    logic [WORD_W-1:0]     write_data;
    logic [WORD_W-1:0]     write_mask;
  } regulator_cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0]     control_word;
    logic                  status;
    logic [LVL_OUT_W-1:0]  level_index;
  } word_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [1:0]       cfg_idx;
  logic [RES_W-1:0] cfg_data;

  rvcc_in_if  in_if ();
  rvcc_out_if out_if ();

  regulator_voltage_code_composer uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  regulator_cmd_t  command_queue[$];
  word_result_t    pending_words[$];
  regulator_cmd_t  next_cmd;

  // predictor copy of the block's state and divider registers
  logic [WORD_W-1:0] shadow_word;
  longint unsigned   div_upper[2];
  longint unsigned   div_lower[2];

  int     send_idle_pct = 0;
  int     stall_pct = 0;
  bit     hold_req = 1'b0;
  bit     hold_done = 1'b0;
  int     hold_left = 0;
  longint cycle_count = 0;
  int     mismatch_count = 0;
  int     beats_in = 0;
  int     beats_out = 0;
  int     volt_total = 0;
  int     volt_rejects = 0;
  int     divider_settings = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic longint unsigned level_mv(int unsigned idx, longint unsigned up,
                                               longint unsigned lo);
    longint unsigned v;
    v = 64'(V_BASE + V_STEP * idx);
    if (lo == 0) lo = 1;
    return v + (v * up) / lo;
  endfunction

  function automatic void volt_window(input longint unsigned up, input longint unsigned lo,
                                      output longint unsigned min_mv,
                                      output longint unsigned max_mv);
    longint unsigned first_lvl, last_lvl, dev;
    first_lvl = level_mv(0, up, lo);
    last_lvl  = level_mv(LEVEL_COUNT - 1, up, lo);
    dev       = ((last_lvl * 1000 / 800) * 125) / 1000;
    min_mv    = (first_lvl > dev) ? first_lvl - dev : 0;
    max_mv    = last_lvl + dev;
  endfunction

  // updates shadow_word and returns the beat the block should send back
  function automatic word_result_t compose_word(regulator_cmd_t c);
    word_result_t    r;
    longint unsigned up, lo, min_mv, max_mv, lvl, gap, best;
    int unsigned     pick;
    r.status      = 1'b0;
    r.level_index = '0;
    case (c.action)
      ACT_SET_VOLT: begin
        volt_total++;
        up = div_upper[c.regulator];
        lo = div_lower[c.regulator];
        volt_window(up, lo, min_mv, max_mv);
        if (c.millivolts < min_mv || c.millivolts > max_mv) begin
          r.status = 1'b1;
          volt_rejects++;
        end else begin
          best = '1;
          pick = 0;
          for (int unsigned i = 0; i < LEVEL_COUNT; i++) begin
            lvl = level_mv(i, up, lo);
            gap = (lvl > c.millivolts) ? lvl - c.millivolts : c.millivolts - lvl;
            // strict compare keeps the lowest index on equal distance
            if (gap < best) begin
              best = gap;
              pick = i;
            end
          end
          r.level_index = pick[LVL_OUT_W-1:0];
          if (c.regulator)
            shadow_word[SW3_LSB +: LVL_OUT_W] = pick[LVL_OUT_W-1:0];
          else
            shadow_word[SW2_LSB +: LVL_OUT_W] = pick[LVL_OUT_W-1:0];
        end
      end
      ACT_SET_MODE:   shadow_word[MODE_LSB +: 2] = c.switch_mode;
      ACT_SET_CHARGE: shadow_word[CHARGE_BIT] = ~c.charge_enable;
      ACT_MASKED:     shadow_word = (shadow_word & ~c.write_mask) | (c.write_data & c.write_mask);
      default: ;
    endcase
    r.control_word = shadow_word;
    return r;
  endfunction

  function automatic regulator_cmd_t make_cmd(action_e act, logic reg_sel,
                                              longint unsigned mv, logic [1:0] mode,
                                              logic enable, logic [WORD_W-1:0] data,
                                              logic [WORD_W-1:0] mask);
    regulator_cmd_t c;
    c.action        = act;
    c.regulator     = reg_sel;
    c.millivolts    = mv[MV_W-1:0];
    c.switch_mode   = mode;
    c.charge_enable = enable;
    c.write_data    = data;
    c.write_mask    = mask;
    return c;
  endfunction

  function automatic regulator_cmd_t random_command();
    regulator_cmd_t  c;
    longint unsigned min_mv, max_mv, top_mv, lvl_a, lvl_b, mv;
    int unsigned     roll, i;
    roll = $urandom_range(99);
    if (roll < 50)      c.action = ACT_SET_VOLT;
    else if (roll < 65) c.action = ACT_SET_MODE;
    else if (roll < 80) c.action = ACT_SET_CHARGE;
    else                c.action = ACT_MASKED;
    c.regulator     = 1'($urandom_range(1));
    c.millivolts    = MV_W'($urandom);
    c.switch_mode   = 2'($urandom);
    c.charge_enable = 1'($urandom);
    c.write_data    = WORD_W'($urandom);
    c.write_mask    = WORD_W'($urandom);
    case ($urandom_range(9))
      0: c.write_mask = '1;
      1: c.write_mask = WORD_W'(1) << $urandom_range(WORD_W - 1);
      default: ;
    endcase
    if (c.action == ACT_SET_VOLT) begin
      volt_window(div_upper[c.regulator], div_lower[c.regulator], min_mv, max_mv);
      top_mv = (max_mv > 16'hFFFF) ? 16'hFFFF : max_mv;
      i      = $urandom_range(LEVEL_COUNT - 2);
      lvl_a  = level_mv(i, div_upper[c.regulator], div_lower[c.regulator]);
      lvl_b  = level_mv(i + 1, div_upper[c.regulator], div_lower[c.regulator]);
      mv     = 64'(c.millivolts);
      roll   = $urandom_range(99);
      if (roll < 50 && min_mv <= top_mv) begin
        mv = 64'($urandom_range(32'(top_mv), 32'(min_mv)));
      end else if (roll < 65 && lvl_b <= 16'hFFFF) begin
        mv = (lvl_a + lvl_b) / 2;   // halfway, a tie when the sum is even
      end else if (roll < 75 && lvl_b <= 16'hFFFF) begin
        mv = lvl_a - 1 + 64'($urandom_range(2));
      end else if (roll < 85 && max_mv < 16'hFFFF) begin
        case ($urandom_range(3))
          0: mv = (min_mv == 0) ? 0 : min_mv - 1;
          1: mv = min_mv;
          2: mv = max_mv;
          default: mv = max_mv + 1;
        endcase
      end
      c.millivolts = mv[MV_W-1:0];
    end
    return c;
  endfunction

  // command driver
  always @(posedge clk_i) begin
    if (!in_if.valid || in_if.ready) begin
      if (command_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_cmd = command_queue.pop_front();
        in_if.valid         <= 1'b1;
        in_if.action        <= next_cmd.action;
        in_if.regulator     <= next_cmd.regulator;
        in_if.millivolts    <= next_cmd.millivolts;
        in_if.switch_mode   <= next_cmd.switch_mode;
        in_if.charge_enable <= next_cmd.charge_enable;
        in_if.write_data    <= next_cmd.write_data;
        in_if.write_mask    <= next_cmd.write_mask;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // predictor: tracks divider writes and accepted command beats
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      shadow_word  = '0;
      div_upper[0] = 0;
      div_lower[0] = 1;
      div_upper[1] = 0;
      div_lower[1] = 1;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_e'(cfg_idx))
          CFG_SW2_UPPER: div_upper[0] = 64'(cfg_data);
          CFG_SW2_LOWER: div_lower[0] = 64'(cfg_data);
          CFG_SW3_UPPER: div_upper[1] = 64'(cfg_data);
          CFG_SW3_LOWER: div_lower[1] = 64'(cfg_data);
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        pending_words.push_back(compose_word(make_cmd(action_e'(in_if.action),
            in_if.regulator, 64'(in_if.millivolts), in_if.switch_mode,
            in_if.charge_enable, in_if.write_data, in_if.write_mask)));
        beats_in++;
      end
    end
  end

  // result receiver: random stalls plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_if.ready <= 1'b0;
      hold_left    <= LONG_HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    word_result_t exp_word;
    if (rst_ni && out_if.valid && out_if.ready) begin
      beats_out++;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("result beat word %h with nothing expected",
                                  out_if.control_word));
      end else begin
        exp_word = pending_words.pop_front();
        if (out_if.control_word !== exp_word.control_word)
          report_mismatch($sformatf("beat %0d control_word %h, expected %h", beats_out,
                                    out_if.control_word, exp_word.control_word));
        if (out_if.status !== exp_word.status)
          report_mismatch($sformatf("beat %0d status %b, expected %b", beats_out,
                                    out_if.status, exp_word.status));
        if (out_if.level_index !== exp_word.level_index)
          report_mismatch($sformatf("beat %0d level_index %0d, expected %0d", beats_out,
                                    out_if.level_index, exp_word.level_index));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_words.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (command_queue.size() != 0 || in_if.valid || pending_words.size() != 0);
  endtask

  task automatic write_divider(cfg_idx_e idx, logic [RES_W-1:0] value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic set_dividers(logic [RES_W-1:0] sw2_up, logic [RES_W-1:0] sw2_lo,
                              logic [RES_W-1:0] sw3_up, logic [RES_W-1:0] sw3_lo);
    write_divider(CFG_SW2_UPPER, sw2_up);
    write_divider(CFG_SW2_LOWER, sw2_lo);
    write_divider(CFG_SW3_UPPER, sw3_up);
    write_divider(CFG_SW3_LOWER, sw3_lo);
    // let the predictor see the last write before stimulus is built
    @(negedge clk_i);
    divider_settings++;
  endtask

  task automatic run_random(int items, int idle, int stall);
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (items) command_queue.push_back(random_command());
    wait_drained();
  endtask

  initial begin
    longint unsigned min_mv, max_mv;
    rst_ni                 = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = CFG_SW2_UPPER;
    cfg_data               = '0;
    in_if.valid            = 1'b0;
    in_if.action           = ACT_SET_VOLT;
    in_if.regulator        = 1'b0;
    in_if.millivolts       = '0;
    in_if.switch_mode      = '0;
    in_if.charge_enable    = 1'b0;
    in_if.write_data       = '0;
    in_if.write_mask       = '0;
    out_if.ready           = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset dividers, every command, window edges
    command_queue.push_back(make_cmd(ACT_SET_MODE, 0, 0, 2'd3, 0, '0, '0));
    command_queue.push_back(make_cmd(ACT_SET_MODE, 1, 0, 2'd0, 1, '1, '1));
    command_queue.push_back(make_cmd(ACT_SET_CHARGE, 0, 0, 2'd0, 0, '0, '0));
    command_queue.push_back(make_cmd(ACT_SET_CHARGE, 0, 0, 2'd0, 1, '0, '0));
    command_queue.push_back(make_cmd(ACT_MASKED, 0, 0, 2'd0, 0, 16'hFFFF, 16'hFFFF));
    command_queue.push_back(make_cmd(ACT_MASKED, 0, 0, 2'd0, 0, 16'h0000, 16'hFFFF));
    command_queue.push_back(make_cmd(ACT_MASKED, 0, 0, 2'd0, 0, 16'hA5A5, 16'h0F0F));
    command_queue.push_back(make_cmd(ACT_SET_VOLT, 0, 0, 0, 0, '0, '0));
    command_queue.push_back(make_cmd(ACT_SET_VOLT, 0, 16'hFFFF, 0, 0, '0, '0));
    volt_window(div_upper[0], div_lower[0], min_mv, max_mv);
    command_queue.push_back(make_cmd(ACT_SET_VOLT, 0, min_mv - 1, 0, 0, '0, '0));
    command_queue.push_back(make_cmd(ACT_SET_VOLT, 0, min_mv, 0, 0, '0, '0));
    command_queue.push_back(make_cmd(ACT_SET_VOLT, 0, max_mv, 0, 0, '0, '0));
    command_queue.push_back(make_cmd(ACT_SET_VOLT, 0, max_mv + 1, 0, 0, '0, '0));
    command_queue.push_back(make_cmd(ACT_SET_VOLT, 1, level_mv(0, 0, 1), 0, 0, '0, '0));
    command_queue.push_back(make_cmd(ACT_SET_VOLT, 1, level_mv(15, 0, 1), 0, 0, '0, '0));
    wait_drained();

    // ties between neighbor levels; zero lower resistor acts as one
    set_dividers(16'd1, 16'd1, 16'd5, 16'd0);
    command_queue.push_back(make_cmd(ACT_SET_VOLT, 0, 875, 0, 0, '0, '0));
    command_queue.push_back(make_cmd(ACT_SET_VOLT, 0,
        (level_mv(7, 1, 1) + level_mv(8, 1, 1)) / 2, 0, 0, '0, '0));
    command_queue.push_back(make_cmd(ACT_SET_VOLT, 1, level_mv(0, 5, 0), 0, 0, '0, '0));
    command_queue.push_back(make_cmd(ACT_SET_VOLT, 1, level_mv(15, 5, 0), 0, 0, '0, '0));
    wait_drained();

    set_dividers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
    command_queue.push_back(make_cmd(ACT_SET_VOLT, 0, 16'hFFFF, 0, 0, '0, '0));
    command_queue.push_back(make_cmd(ACT_SET_VOLT, 0, level_mv(15, 1, 1), 0, 0, '0, '0));
    command_queue.push_back(make_cmd(ACT_SET_VOLT, 1, 16'hFFFF, 0, 0, '0, '0));
    command_queue.push_back(make_cmd(ACT_SET_VOLT, 1, 0, 0, 0, '0, '0));
    wait_drained();

    set_dividers(16'd0, 16'd1, 16'd3, 16'd2);
    run_random(ITEMS_PER_PHASE, 0, 0);
    set_dividers(16'hFFFF, 16'hFFFF, 16'd20, 16'd7);
    run_random(ITEMS_PER_PHASE, 75, 0);
    set_dividers(16'hFFFF, 16'd1, 16'd123, 16'd457);
    run_random(ITEMS_PER_PHASE, 0, 75);
    set_dividers(16'd7, 16'd3, 16'd0, 16'hFFFF);
    run_random(ITEMS_PER_PHASE, 31, 31);

    // long receiver hold-off while commands keep coming: block fills and stalls
    set_dividers(16'd1, 16'd1, 16'd2, 16'd5);
    hold_req = 1'b1;
    run_random(ITEMS_PER_PHASE, 0, 0);

    // catch any stray beat after the last result
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Run: %0d commands in, %0d results out, %0d voltage requests (%0d rejected)",
             beats_in, beats_out, volt_total, volt_rejects);
    $display("Divider settings exercised: %0d, mismatches: %0d", divider_settings + 1,
             mismatch_count);
    if (mismatch_count == 0 && pending_words.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
